FILE: rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Widths and codes shared by the cosine similarity engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int DOT_W       = 42;
  localparam int NRG_W       = 41;
  localparam int NPROD_W     = 2 * NRG_W;
  localparam int ROOT_W      = NRG_W;
  localparam int SUB_W       = 44;
  localparam int MUL_W       = 22;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int CHUNK_W     = 21;
  localparam int STEP_W      = 6;

  typedef enum logic [2:0] {
    DST_DOT,
    DST_EA,
    DST_EB,
    DST_P0,
    DST_P21,
    DST_P42
  } dst_t;

endpackage

`default_nettype wire

FILE: rtl/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Accumulates dot product and both energies of a streamed vector pair and,
// on the last pair, returns dot * 2^15 / isqrt(energy_a * energy_b) in Q1.15.
//
//   channel   dir  tdata                          tuser / tlast
//   s_axis    in   [15:0] elem_a, [31:16] elem_b  tlast = last_elem
//   m_axis    out  [15:0] similarity              [0] zero_norm, [1] overlong
//   min_energy in  41-bit threshold, write on min_energy_wr_en
//
// A pair holds the input while it runs three products and a drain step on the
// shared 22x22 multiplier, then, unless it is the last, returns to idle. A last
// pair then adds a threshold check, the four partial products of the energy
// product and a drain step, the bit-serial square root, the divide on the
// shared subtractor and the load of the output register. The result waits in
// the output register without blocking input; a new result waits for it to drain.
// rst clears the sequencer, accumulators, threshold and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_engine
  import cse_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  wire logic        s_axis_tlast,   // last_elem
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] similarity
  output logic [1:0]       m_axis_tuser,   // [0] zero_norm, [1] overlong
  input  wire logic        min_energy_wr_en,
  input  wire logic [40:0] min_energy_wr_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_NPROD = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [STEP_W-1:0] MAC_LAST   = STEP_W'(3);
  localparam logic [STEP_W-1:0] NPROD_LAST = STEP_W'(4);
  localparam logic [STEP_W-1:0] SQRT_LAST  = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(FRAC_BITS + 1);
  localparam logic [15:0]       SIM_MAX    = 16'h7fff;
  localparam logic [15:0]       SIM_MIN    = 16'h8000;
  localparam logic [15:0]       Q_ONE      = 16'h8000;

  logic [2:0]               state;
  logic [STEP_W-1:0]        step;
  logic [40:0]              min_energy;
  logic signed [15:0]       elem_a;
  logic signed [15:0]       elem_b;
  logic                     last;
  logic [DOT_W-1:0]         dot_acc;
  logic [NRG_W-1:0]         energy_a;
  logic [NRG_W-1:0]         energy_b;
  logic [CNT_W-1:0]         elem_count;
  logic                     too_long;
  logic                     zero;
  logic signed [MUL_W-1:0]  mul_x;
  logic signed [MUL_W-1:0]  mul_y;
  logic                     mul_go;
  dst_t                     mul_dst;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  dst_t                     prod_dst;
  logic [NPROD_W-1:0]       nprod;
  logic [ROOT_W-1:0]        root;
  logic [SUB_W-1:0]         rem;
  logic [15:0]              quo;
  logic [15:0]              quo_next;
  logic [15:0]              sim;
  logic [DOT_W-1:0]         mag;
  logic [SUB_W-1:0]         sub_a;
  logic [SUB_W-1:0]         sub_b;
  logic [SUB_W:0]           diff;
  logic                     ge;
  logic                     out_free;
  logic                     accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign mag           = dot_acc[DOT_W-1] ? (~dot_acc + DOT_W'(1)) : dot_acc;

  // shared multiplier operand select
  always_comb begin
    mul_x   = '0;
    mul_y   = '0;
    mul_go  = 1'b0;
    mul_dst = DST_DOT;
    if (state == S_MAC) begin
      mul_go = (step != MAC_LAST);
      unique case (step[1:0])
        2'd0: begin
          mul_x   = MUL_W'(elem_a);
          mul_y   = MUL_W'(elem_b);
          mul_dst = DST_DOT;
        end
        2'd1: begin
          mul_x   = MUL_W'(elem_a);
          mul_y   = MUL_W'(elem_a);
          mul_dst = DST_EA;
        end
        2'd2: begin
          mul_x   = MUL_W'(elem_b);
          mul_y   = MUL_W'(elem_b);
          mul_dst = DST_EB;
        end
        default: begin
          mul_x   = '0;
          mul_y   = '0;
          mul_dst = DST_DOT;
        end
      endcase
    end else if (state == S_NPROD) begin
      mul_go = (step != NPROD_LAST);
      unique case (step[1:0])
        2'd0: begin
          mul_x   = MUL_W'({1'b0, energy_a[CHUNK_W-1:0]});
          mul_y   = MUL_W'({1'b0, energy_b[CHUNK_W-1:0]});
          mul_dst = DST_P0;
        end
        2'd1: begin
          mul_x   = MUL_W'({1'b0, energy_a[CHUNK_W-1:0]});
          mul_y   = MUL_W'({1'b0, energy_b[NRG_W-1:CHUNK_W]});
          mul_dst = DST_P21;
        end
        2'd2: begin
          mul_x   = MUL_W'({1'b0, energy_a[NRG_W-1:CHUNK_W]});
          mul_y   = MUL_W'({1'b0, energy_b[CHUNK_W-1:0]});
          mul_dst = DST_P21;
        end
        default: begin
          mul_x   = MUL_W'({1'b0, energy_a[NRG_W-1:CHUNK_W]});
          mul_y   = MUL_W'({1'b0, energy_b[NRG_W-1:CHUNK_W]});
          mul_dst = DST_P42;
        end
      endcase
    end
  end

  // shared subtractor for square root and divide
  always_comb begin
    sub_a = rem;
    sub_b = '0;
    if (state == S_SQRT) begin
      sub_a = {rem[SUB_W-3:0], nprod[NPROD_W-1 -: 2]};
      sub_b = SUB_W'({root, 2'b01});
    end else if (state == S_DIV) begin
      if (step == '0) begin
        sub_a = rem;
        sub_b = SUB_W'({root, 1'b0});
      end else if (step == STEP_W'(1)) begin
        sub_a = rem;
        sub_b = SUB_W'(root);
      end else begin
        sub_a = {rem[SUB_W-2:0], 1'b0};
        sub_b = SUB_W'(root);
      end
    end
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = !diff[SUB_W];
  assign quo_next = {quo[14:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_energy <= '0;
    end else if (min_energy_wr_en) begin
      min_energy <= min_energy_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= mul_x * mul_y;
    prod_dst <= mul_dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      prod_vld      <= 1'b0;
      dot_acc       <= '0;
      energy_a      <= '0;
      energy_b      <= '0;
      elem_count    <= '0;
      too_long      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      prod_vld <= mul_go;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (prod_vld) begin
        unique case (prod_dst)
          DST_DOT: dot_acc  <= dot_acc + prod[DOT_W-1:0];
          DST_EA:  energy_a <= energy_a + prod[NRG_W-1:0];
          DST_EB:  energy_b <= energy_b + prod[NRG_W-1:0];
          DST_P0:  nprod    <= nprod + NPROD_W'($unsigned(prod));
          DST_P21: nprod    <= nprod + (NPROD_W'($unsigned(prod)) << CHUNK_W);
          DST_P42: nprod    <= nprod + (NPROD_W'($unsigned(prod)) << (2 * CHUNK_W));
          default: nprod    <= nprod;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            elem_a <= s_axis_tdata[15:0];
            elem_b <= s_axis_tdata[31:16];
            last   <= s_axis_tlast;
            if (elem_count == CNT_W'(MAX_LEN)) begin
              too_long <= 1'b1;
            end else begin
              elem_count <= elem_count + CNT_W'(1);
            end
            step  <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          step <= step + STEP_W'(1);
          if (step == MAC_LAST) begin
            state <= last ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          zero  <= (energy_a <= min_energy) || (energy_b <= min_energy);
          nprod <= '0;
          step  <= '0;
          if ((energy_a <= min_energy) || (energy_b <= min_energy)) begin
            sim   <= '0;
            state <= S_FIN;
          end else begin
            state <= S_NPROD;
          end
        end
        S_NPROD: begin
          step <= step + STEP_W'(1);
          if (step == NPROD_LAST) begin
            root  <= '0;
            rem   <= '0;
            step  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          nprod <= nprod << 2;
          if (ge) begin
            rem  <= diff[SUB_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= sub_a;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == SQRT_LAST) begin
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          step <= step + STEP_W'(1);
          if (step == '0) begin
            rem <= SUB_W'(mag);
            quo <= '0;
            if (root == '0) begin
              sim   <= '0;
              state <= S_FIN;
            end else if (SUB_W'(mag) >= SUB_W'({root, 1'b0})) begin
              sim   <= dot_acc[DOT_W-1] ? SIM_MIN : SIM_MAX;
              state <= S_FIN;
            end
          end else begin
            quo <= quo_next;
            rem <= ge ? diff[SUB_W-1:0] : sub_a;
            if (step == DIV_LAST) begin
              if (dot_acc[DOT_W-1]) begin
                sim <= (quo_next > Q_ONE) ? SIM_MIN : (~quo_next + 16'd1);
              end else begin
                sim <= (quo_next > SIM_MAX) ? SIM_MAX : quo_next;
              end
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= sim;
            m_axis_tuser  <= {too_long, zero};
            dot_acc       <= '0;
            energy_a      <= '0;
            energy_b      <= '0;
            elem_count    <= '0;
            too_long      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sim/cosine_similarity_checker.sv
// ----------------------------------------------------------------------------
// cosine_similarity_checker
// Watches the pair and result streams of the cosine similarity engine and the
// min_energy write port. For every accepted pair it updates its own copy of
// the dot product and both energies; on a last pair it predicts similarity,
// zero_norm and overlong and queues them. Each result beat is compared field
// by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module cosine_similarity_checker
  import cse_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        s_axis_tlast,   // last_elem
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [15:0] similarity
  input  logic [1:0]  m_axis_tuser,   // [0] zero_norm, [1] overlong
  input  logic        min_energy_wr_en,
  input  logic [40:0] min_energy_wr_data,
  output int          fail_count,
  output int          results_pending,
  output int          results_seen
);

  typedef struct packed {
    logic [15:0] similarity;
    logic        zero_norm;
    logic        overlong;
  } cosine_result_t;

  cosine_result_t   expected_results[$];
  logic [NRG_W-1:0] threshold;
  logic [DOT_W-1:0] dot_sum;
  logic [NRG_W-1:0] energy_a;
  logic [NRG_W-1:0] energy_b;
  int               pair_count;
  logic             too_long;

  function automatic logic [15:0] cosine_q15(logic [DOT_W-1:0] dot,
                                             logic [NRG_W-1:0] ea,
                                             logic [NRG_W-1:0] eb);
    logic [NPROD_W-1:0] norm_prod;
    logic [NRG_W-1:0]   root;
    logic [NRG_W-1:0]   trial;
    logic [83:0]        trial_sq;
    logic [DOT_W-1:0]   mag;
    logic [63:0]        quo;
    logic               neg;
    int                 i;
    norm_prod = ea * eb;
    root = '0;
    for (i = NRG_W - 1; i >= 0; i--) begin
      trial = root | (41'd1 << i);
      trial_sq = trial * trial;
      if (trial_sq <= {2'b00, norm_prod}) root = trial;
    end
    if (root == '0) return 16'd0;
    neg = dot[DOT_W-1];
    mag = neg ? (~dot + 1'b1) : dot;
    quo = {7'd0, mag, 15'd0} / {23'd0, root};
    if (neg) begin
      if (quo > 64'd32768) quo = 64'd32768;
      return 16'd0 - quo[15:0];
    end
    if (quo > 64'd32767) quo = 64'd32767;
    return quo[15:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic accumulate_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    logic signed [31:0] prod_ab;
    logic signed [31:0] prod_aa;
    logic signed [31:0] prod_bb;
    cosine_result_t     result;
    prod_ab = a * b;
    prod_aa = a * a;
    prod_bb = b * b;
    dot_sum  = dot_sum + {{(DOT_W-32){prod_ab[31]}}, prod_ab};
    energy_a = energy_a + {{(NRG_W-32){1'b0}}, prod_aa};
    energy_b = energy_b + {{(NRG_W-32){1'b0}}, prod_bb};
    if (pair_count >= MAX_LEN) too_long = 1'b1;
    else pair_count++;
    if (last) begin
      result.zero_norm  = (energy_a <= threshold) || (energy_b <= threshold);
      result.similarity = result.zero_norm ? 16'd0 : cosine_q15(dot_sum, energy_a, energy_b);
      result.overlong   = too_long;
      expected_results.push_back(result);
      dot_sum    = '0;
      energy_a   = '0;
      energy_b   = '0;
      pair_count = 0;
      too_long   = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    cosine_result_t want;
    if (rst) begin
      threshold  = '0;
      dot_sum    = '0;
      energy_a   = '0;
      energy_b   = '0;
      pair_count = 0;
      too_long   = 1'b0;
    end else begin
      if (min_energy_wr_en) threshold = min_energy_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none pending", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.similarity)
            report_mismatch($sformatf("result %0d similarity %h, want %h",
                                      results_seen, m_axis_tdata, want.similarity));
          if (m_axis_tuser[0] !== want.zero_norm)
            report_mismatch($sformatf("result %0d zero_norm %b, want %b",
                                      results_seen, m_axis_tuser[0], want.zero_norm));
          if (m_axis_tuser[1] !== want.overlong)
            report_mismatch($sformatf("result %0d overlong %b, want %b",
                                      results_seen, m_axis_tuser[1], want.overlong));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        accumulate_pair(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
    end
    results_pending = expected_results.size();
  end

endmodule

FILE: sim/cosine_similarity_engine_test.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine_test
// Streams vector pairs into the cosine similarity engine with random gaps and
// output stalls: a directed set of corner cases (full scale, exact and
// opposite match, zero vectors, energy at the threshold), then random vectors
// of many shapes, two of them at and past the maximum length, under a series
// of min_energy settings. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_test;

  localparam int MAX_LEN = 1024;

  typedef enum {
    STY_RANDOM,
    STY_SMALL,
    STY_SAME,
    STY_NEGATED,
    STY_NEAR,
    STY_FULL_SCALE,
    STY_SPARSE,
    STY_ZERO_SIDE
  } vec_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [15:0] elem_a, [31:16] elem_b
  logic        s_axis_tlast = 1'b0;  // last_elem
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] similarity
  logic [1:0]  m_axis_tuser;         // [0] zero_norm, [1] overlong
  logic        min_energy_wr_en = 1'b0;
  logic [40:0] min_energy_wr_data = '0;

  int fail_count;
  int results_pending;
  int results_seen;
  int pairs_sent = 0;
  int settings_used = 1;
  bit sender_calm = 1'b0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  cosine_similarity_engine #(.MAX_LEN(MAX_LEN)) dut (
    .clk                (clk),
    .rst                (rst),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tlast       (s_axis_tlast),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser),
    .min_energy_wr_en   (min_energy_wr_en),
    .min_energy_wr_data (min_energy_wr_data)
  );

  cosine_similarity_checker #(.MAX_LEN(MAX_LEN)) scoreboard (
    .clk                (clk),
    .rst                (rst),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tlast       (s_axis_tlast),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser),
    .min_energy_wr_en   (min_energy_wr_en),
    .min_energy_wr_data (min_energy_wr_data),
    .fail_count         (fail_count),
    .results_pending    (results_pending),
    .results_seen       (results_seen)
  );

  task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
    int gap;
    if (pairs_sent % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic send_vector(int len, vec_style_t style);
    logic [15:0] a;
    logic [15:0] b;
    int          k;
    for (k = 0; k < len; k++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (style)
        STY_RANDOM: ;
        STY_SMALL: begin
          a = 16'($urandom_range(0, 64)) - 16'd32;
          b = 16'($urandom_range(0, 64)) - 16'd32;
        end
        STY_SAME: b = a;
        STY_NEGATED: b = 16'd0 - a;
        STY_NEAR: b = a + 16'($urandom_range(0, 15)) - 16'd8;
        STY_FULL_SCALE: begin
          a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
          b = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        end
        STY_SPARSE: begin
          if ($urandom_range(0, 3) != 0) a = 16'd0;
          if ($urandom_range(0, 3) != 0) b = 16'd0;
        end
        STY_ZERO_SIDE: b = 16'd0;
      endcase
      send_pair(a, b, k == len - 1);
    end
  endtask

  // drain all results and let the engine settle before touching the register
  task automatic write_min_energy(logic [40:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    min_energy_wr_en   <= 1'b1;
    min_energy_wr_data <= value;
    @(posedge clk);
    min_energy_wr_en   <= 1'b0;
    settings_used++;
  endtask

  initial begin : rx_side
    int stall;
    bit calm;
    int taken;
    calm  = 1'b0;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int          phase;
    int          phase_pairs;
    int          vec_len;
    logic [40:0] level;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // threshold 0 after reset
    send_vector(1, STY_SAME);
    send_pair(16'h7fff, 16'h7fff, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7fff, 1'b1);
    send_pair(16'h0000, 16'd12345, 1'b1);
    send_pair(16'd1, 16'd0, 1'b0);
    send_pair(16'd0, 16'd1, 1'b1);
    send_pair(16'd100, 16'hff38, 1'b0);
    send_pair(16'hfed4, 16'd400, 1'b1);

    // energy exactly at the threshold counts as zero
    write_min_energy(41'd1 << 30);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7fff, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'd1, 16'd1, 1'b1);

    write_min_energy(41'd1 << 40);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h1234, 16'hedcb, 1'b1);

    for (phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: level = '0;
        1: level = 41'($urandom_range(0, 1000));
        2: level = (phase == 6) ? (41'd1 << 40) : 41'({$urandom, $urandom} >> 30);
        default: level = 41'({$urandom, $urandom} >> $urandom_range(24, 63));
      endcase
      write_min_energy(level);
      if (phase == 4) send_vector(MAX_LEN, STY_FULL_SCALE);
      if (phase == 8) send_vector(MAX_LEN + 1 + int'($urandom_range(0, 8)), STY_FULL_SCALE);
      phase_pairs = 0;
      while (phase_pairs < 30) begin
        vec_len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(17, 64))
                                              : int'($urandom_range(1, 16));
        phase_pairs += vec_len;
        send_vector(vec_len, vec_style_t'($urandom_range(0, 7)));
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d element pairs, checked %0d similarity results", pairs_sent, results_seen);
    $display("min_energy settings used: %0d, including 0 and 2^40", settings_used);
    if (fail_count == 0)
      $display("[cosine_similarity_engine] OK");
    else
      $display("[cosine_similarity_engine] ERROR");
    $finish;
  end

  initial begin : watchdog
    #(12 * 1000000);
    $display("timeout waiting for the engine");
    $display("[cosine_similarity_engine] ERROR");
    $finish;
  end

endmodule
